>>> design/utf8_stream_cleaner_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 stream cleaner assertion macros
// Concurrent assertion wrappers that are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_CLEANER_ASSERT_SVH
`define UTF8_STREAM_CLEANER_ASSERT_SVH

`ifndef SYNTHESIS

`define U8SC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same cycle implication");

`define U8SC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle implication");

`else

`define U8SC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define U8SC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/u8sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream cleaner package
// Shared types and byte classification constants.
// ----------------------------------------------------------------------------
package u8sc_pkg;

    localparam logic [7:0] C_TAB         = 8'h09;
    localparam logic [7:0] C_LF          = 8'h0A;
    localparam logic [7:0] C_CR          = 8'h0D;
    localparam logic [7:0] C_PRINT_LO    = 8'h20;
    localparam logic [7:0] C_PRINT_HI    = 8'd127;
    localparam logic [7:0] C_MASK_CONT   = 8'hC0;
    localparam logic [7:0] C_PAT_CONT    = 8'h80;
    localparam logic [7:0] C_MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] C_PAT_LEAD2   = 8'hC0;
    localparam logic [7:0] C_MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] C_PAT_LEAD3   = 8'hE0;
    localparam logic [7:0] C_MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] C_PAT_LEAD4   = 8'hF0;

    localparam logic [2:0] C_LEN_NONE    = 3'd0;
    localparam logic [2:0] C_LEN_2       = 3'd2;
    localparam logic [2:0] C_LEN_3       = 3'd3;
    localparam logic [2:0] C_LEN_4       = 3'd4;

    localparam int C_BURST_MAX = 4;

    typedef struct packed {
        logic [C_BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                  count;
        logic                        has_byte;
        logic                        str_end;
    } t_burst;

endpackage

>>> design/u8sc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream cleaner channels
// Valid/ready channels for raw input words and cleaned result words.
// ----------------------------------------------------------------------------
interface u8sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_of_string;

    modport source (output valid, output in_byte, output last_of_string, input ready);
    modport sink   (input valid, input in_byte, input last_of_string, output ready);
endinterface

interface u8sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input string_end, output ready);
endinterface

>>> design/u8sc_burst_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream cleaner result serializer
// Holds the results of one input word and sends them out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
`include "utf8_stream_cleaner_assert.svh"

module u8sc_burst_q
    import u8sc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  t_burst         i_burst,
    output logic           o_can_load,
    u8sc_out_if.source     o_out
);

    logic [2:0]                  r_left;
    logic [C_BURST_MAX-1:0][7:0] r_bytes;
    logic                        r_has;
    logic                        r_end;
    logic                        take;

    assign take       = o_out.valid && o_out.ready;
    assign o_can_load = (r_left == 3'd0) || ((r_left == 3'd1) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_burst.count;
        end else if (take) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_has   <= i_burst.has_byte;
            r_end   <= i_burst.str_end;
        end else if (take) begin
            for (int i = 0; i < C_BURST_MAX - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
        end
    end

    assign o_out.valid      = (r_left != 3'd0);
    assign o_out.out_byte   = r_bytes[0];
    assign o_out.has_byte   = r_has;
    assign o_out.run_last   = (r_left == 3'd1);
    assign o_out.string_end = (r_left == 3'd1) && r_end;

    `U8SC_ASSERT_IMPLIES(a_left_max, i_clk, i_rst_n, 1'b1, r_left <= 3'd4)
    `U8SC_ASSERT_IMPLIES(a_load_free, i_clk, i_rst_n, i_load,
                         (r_left == 3'd0) || ((r_left == 3'd1) && o_out.ready))
    `U8SC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready && !i_load,
                      r_left == $past(r_left))

endmodule

>>> design/utf8_stream_cleaner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream cleaner
// Filters a byte stream down to tab, LF, CR, printable ASCII, DEL and complete
// multi-byte sequences, and marks the end of each string.
// ----------------------------------------------------------------------------
// A word is classified and the sequence state updated in the cycle it is
// accepted, and its results appear in the cycle after, one result word per
// ready cycle. A word that causes several results holds the output serializer
// until drained, so the input is stalled after a completed multi-byte sequence
// or a final byte that releases several results. Otherwise one word is accepted
// every cycle, provided the last result of the previous word is taken in that
// same cycle; while that result is stalled, no input word is accepted.
// ----------------------------------------------------------------------------
`include "utf8_stream_cleaner_assert.svh"

module utf8_stream_cleaner
    import u8sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8sc_in_if.sink    i_in,
    u8sc_out_if.source o_out
);

    logic [2:0][7:0] r_hb;
    logic [1:0]      r_held;
    logic [2:0]      r_needed;
    logic [2:0][7:0] n_hb;
    logic [1:0]      n_held;
    logic [2:0]      n_needed;
    t_burst          burst;
    logic            can_load;
    logic            accept;
    logic            load;

    always_comb begin
        logic [7:0] b;
        logic       cont;
        logic       open;
        logic       printable;

        b         = i_in.in_byte;
        cont      = (b & C_MASK_CONT) == C_PAT_CONT;
        open      = (r_needed != C_LEN_NONE);
        printable = (b == C_TAB) || (b == C_LF) || (b == C_CR) ||
                    ((b >= C_PRINT_LO) && (b <= C_PRINT_HI));

        n_hb           = r_hb;
        n_held         = r_held;
        n_needed       = r_needed;
        burst.bytes    = {C_BURST_MAX{b}};
        burst.count    = 3'd0;
        burst.has_byte = 1'b1;
        burst.str_end  = i_in.last_of_string;

        if (open && cont) begin
            if (({1'b0, r_held} + 3'd1) >= r_needed) begin
                for (int i = 0; i < 3; i++) begin
                    if (i < int'(r_held)) begin
                        burst.bytes[i] = r_hb[i];
                    end
                end
                burst.bytes[r_held] = b;
                burst.count         = {1'b0, r_held} + 3'd1;
                n_held              = 2'd0;
                n_needed            = C_LEN_NONE;
            end else begin
                n_hb[r_held] = b;
                n_held       = r_held + 2'd1;
            end
        end else begin
            n_held   = 2'd0;
            n_needed = C_LEN_NONE;
            priority if (printable) begin
                burst.bytes[0] = b;
                burst.count    = 3'd1;
            end else if ((b & C_MASK_LEAD2) == C_PAT_LEAD2) begin
                n_hb[0]  = b;
                n_held   = 2'd1;
                n_needed = C_LEN_2;
            end else if ((b & C_MASK_LEAD3) == C_PAT_LEAD3) begin
                n_hb[0]  = b;
                n_held   = 2'd1;
                n_needed = C_LEN_3;
            end else if ((b & C_MASK_LEAD4) == C_PAT_LEAD4) begin
                n_hb[0]  = b;
                n_held   = 2'd1;
                n_needed = C_LEN_4;
            end else begin
                n_held = 2'd0;
            end
        end

        if (i_in.last_of_string) begin
            n_held   = 2'd0;
            n_needed = C_LEN_NONE;
            if (burst.count == 3'd0) begin
                burst.bytes[0] = 8'h00;
                burst.count    = 3'd1;
                burst.has_byte = 1'b0;
            end
        end
    end

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;
    assign load       = accept && (burst.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 2'd0;
            r_needed <= C_LEN_NONE;
        end else if (accept) begin
            r_held   <= n_held;
            r_needed <= n_needed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hb <= n_hb;
        end
    end

    u8sc_burst_q u_burst_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    `U8SC_ASSERT_IMPLIES(a_closed_empty, i_clk, i_rst_n, r_needed == C_LEN_NONE,
                         r_held == 2'd0)
    `U8SC_ASSERT_IMPLIES(a_open_held, i_clk, i_rst_n, r_needed != C_LEN_NONE,
                         (r_held != 2'd0) && ({1'b0, r_held} < r_needed))
    `U8SC_ASSERT_NEXT(a_end_closes, i_clk, i_rst_n, accept && i_in.last_of_string,
                      r_needed == C_LEN_NONE)

endmodule
